FILE: rtl/vtc_pkg.sv
// Package: shared types and codes of the vertex transform chain.
`timescale 1ns / 1ps
`default_nettype none
package vtc_pkg;
  typedef enum logic [2:0] {
    ACT_CHAIN   = 3'd0,
    ACT_REPLACE = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_VERTEX  = 3'd4
  } action_t;

  localparam logic [1:0] KIND_ROT   = 2'd0;
  localparam logic [1:0] KIND_SCALE = 2'd1;
  localparam logic [1:0] KIND_TRANS = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_LOAD,
    S_MUL,
    S_WR,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/vtc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module vtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/vertex_transform_chain.sv
// Top level: transform list held in RAM and a sequencer over one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps an ordered list of up to MAX_ENTRIES rotation, scale or
// translation entries in two RAMs (kinds, and four 32-bit components per entry)
// and answers every input transaction with one result transaction. One item
// is handled at a time. Delete, clear and unused action codes go straight to
// the result, and a replace or an add to an empty list writes the entry
// directly. A chain add on a non-empty list first fetches the last entry and
// then writes four components: directly for an append or a translation merge,
// after three products for a scale merge and after sixteen products through
// the shared multiplier for a rotation merge. A vertex is handled by fetching
// each stored entry in turn and stepping on, with 15 products for a rotation,
// 3 for a scale and none for a translation. The single multiplier and the
// one RAM port set the rate.
// The result waits in an output register; the next item is taken once it has gone.
module vertex_transform_chain
  import vtc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // comp_a, comp_b, comp_c, comp_d
  input  wire logic [4:0]   in_tuser,  // action, kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata, // out_x, out_y, out_z
  output logic [1:0]        out_tuser  // status
);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = IW + 2;
  localparam int DEPTH = (MAX_ENTRIES > 1) ? MAX_ENTRIES : 2;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0] act_r;
  logic [1:0] kind_r, ekind_r;
  logic [31:0] c_r [4];
  logic [31:0] e_r [4];
  logic [31:0] v_r [3];
  logic [31:0] t_r [3];
  logic [31:0] acc_r;
  logic [IW-1:0] idx_r;
  logic [2:0] ld_r;
  logic [4:0] step_r;
  logic mph_r;
  logic signed [63:0] prod_r;
  logic [1:0] st_r;
  logic [1:0] wcnt_r;
  logic [31:0] res_r [4];
  logic ovalid_r;

  // RAM ports
  logic           k_we, c_we;
  logic [IW-1:0]  k_addr;
  logic [AW-1:0]  c_addr;
  logic [1:0]     k_wd, k_rd;
  logic [31:0]    c_wd, c_rd;

  vtc_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_kinds (
    .clk(clk), .we(k_we), .addr(k_addr), .wdata(k_wd), .rdata(k_rd));
  vtc_ram #(.WIDTH(32), .DEPTH(4 * DEPTH)) u_comps (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));

  // Product schedule: operand selection per step.
  logic [31:0] ma, mb;
  logic        sub;
  logic        last_step;
  logic [31:0] fm;
  assign fm = 32'(prod_r >>> FRAC_BITS);

  logic is_rot, is_merge;
  assign is_rot   = (ekind_r == KIND_ROT);
  assign is_merge = (act_r != ACT_VERTEX);

  always_comb begin
    ma = '0; mb = '0; sub = 1'b0; last_step = 1'b0;
    if (is_merge && is_rot) begin
      // Hamilton product e*c, four terms per output component.
      case (step_r)
        5'd0:  begin ma = e_r[3]; mb = c_r[0]; end
        5'd1:  begin ma = e_r[0]; mb = c_r[3]; end
        5'd2:  begin ma = e_r[1]; mb = c_r[2]; end
        5'd3:  begin ma = e_r[2]; mb = c_r[1]; sub = 1'b1; end
        5'd4:  begin ma = e_r[3]; mb = c_r[1]; end
        5'd5:  begin ma = e_r[1]; mb = c_r[3]; end
        5'd6:  begin ma = e_r[2]; mb = c_r[0]; end
        5'd7:  begin ma = e_r[0]; mb = c_r[2]; sub = 1'b1; end
        5'd8:  begin ma = e_r[3]; mb = c_r[2]; end
        5'd9:  begin ma = e_r[2]; mb = c_r[3]; end
        5'd10: begin ma = e_r[0]; mb = c_r[1]; end
        5'd11: begin ma = e_r[1]; mb = c_r[0]; sub = 1'b1; end
        5'd12: begin ma = e_r[3]; mb = c_r[3]; end
        5'd13: begin ma = e_r[0]; mb = c_r[0]; sub = 1'b1; end
        5'd14: begin ma = e_r[1]; mb = c_r[1]; sub = 1'b1; end
        5'd15: begin ma = e_r[2]; mb = c_r[2]; sub = 1'b1; last_step = 1'b1; end
        default: ;
      endcase
    end else if (!is_rot) begin
      // Componentwise scale, either of the stored entry or of the vertex.
      case (step_r)
        5'd0: begin ma = e_r[0]; mb = is_merge ? c_r[0] : v_r[0]; end
        5'd1: begin ma = e_r[1]; mb = is_merge ? c_r[1] : v_r[1]; end
        5'd2: begin ma = e_r[2]; mb = is_merge ? c_r[2] : v_r[2]; last_step = 1'b1; end
        default: ;
      endcase
    end else begin
      // Steps 0-5: t = cross(q,v). 6-11: cross(q,2t). 12-14: w*2t.
      case (step_r)
        5'd0:  begin ma = e_r[1]; mb = v_r[2]; end
        5'd1:  begin ma = e_r[2]; mb = v_r[1]; sub = 1'b1; end
        5'd2:  begin ma = e_r[2]; mb = v_r[0]; end
        5'd3:  begin ma = e_r[0]; mb = v_r[2]; sub = 1'b1; end
        5'd4:  begin ma = e_r[0]; mb = v_r[1]; end
        5'd5:  begin ma = e_r[1]; mb = v_r[0]; sub = 1'b1; end
        5'd6:  begin ma = e_r[1]; mb = t_r[2]; end
        5'd7:  begin ma = e_r[2]; mb = t_r[1]; sub = 1'b1; end
        5'd8:  begin ma = e_r[2]; mb = t_r[0]; end
        5'd9:  begin ma = e_r[0]; mb = t_r[2]; sub = 1'b1; end
        5'd10: begin ma = e_r[0]; mb = t_r[1]; end
        5'd11: begin ma = e_r[1]; mb = t_r[0]; sub = 1'b1; end
        5'd12: begin ma = e_r[3]; mb = t_r[0]; end
        5'd13: begin ma = e_r[3]; mb = t_r[1]; end
        5'd14: begin ma = e_r[3]; mb = t_r[2]; last_step = 1'b1; end
        default: ;
      endcase
    end
  end

  logic [31:0] acc_sum;
  assign acc_sum = sub ? (acc_r - fm) : (acc_r + fm);

  logic [IW-1:0] last_idx;
  assign last_idx = IW'(count_r - CW'(1));
  logic do_add, kind_ok;
  assign kind_ok = (kind_r != 2'd3);
  assign do_add = (act_r == ACT_CHAIN || act_r == ACT_REPLACE) && kind_ok;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_RD;
      S_RD: begin
        if (act_r == ACT_VERTEX) begin
          state_nxt = (count_r == '0) ? S_DONE : S_LOAD;
        end else if (do_add && count_r != '0 && act_r == ACT_CHAIN) begin
          state_nxt = S_LOAD;
        end else if (do_add) begin
          state_nxt = S_WR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LOAD: begin
        if (ld_r == 3'd5) begin
          if (act_r == ACT_VERTEX) begin
            state_nxt = (k_rd == KIND_TRANS || k_rd == 2'd3) ? S_WR : S_MUL;
          end else if (k_rd != kind_r) begin
            state_nxt = (count_r == CW'(MAX_ENTRIES)) ? S_DONE : S_WR;
          end else if (kind_r == KIND_TRANS) begin
            state_nxt = S_WR;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: if (mph_r && last_step) state_nxt = S_WR;
      S_WR: begin
        if (act_r == ACT_VERTEX) begin
          state_nxt = (idx_r == last_idx) ? S_DONE : S_LOAD;
        end else if (wcnt_r == 2'd3) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Append target and write-back values.
  logic append;
  assign append = (count_r == '0) || (act_r == ACT_CHAIN && ekind_r != kind_r);
  logic [IW-1:0] widx;
  assign widx = append ? IW'(count_r) : last_idx;
  logic [31:0] wval;
  always_comb begin
    if (append || act_r == ACT_REPLACE) wval = c_r[wcnt_r];
    else if (kind_r == KIND_TRANS && wcnt_r != 2'd3) wval = e_r[wcnt_r] + c_r[wcnt_r];
    else wval = e_r[wcnt_r];
  end

  // RAM control outputs
  always_comb begin
    k_we = 1'b0; c_we = 1'b0; k_wd = kind_r; c_wd = wval;
    k_addr = idx_r; c_addr = {idx_r, ld_r[1:0]};
    case (state_r)
      S_RD: begin k_addr = idx_r; c_addr = {idx_r, 2'd0}; end
      S_LOAD: begin
        k_addr = idx_r;
        c_addr = {idx_r, (ld_r < 3'd4) ? ld_r[1:0] : 2'd3};
      end
      S_WR: if (act_r != ACT_VERTEX) begin
        k_we = (wcnt_r == 2'd0); c_we = 1'b1;
        k_addr = widx; c_addr = {widx, wcnt_r};
      end
      default: ;
    endcase
  end

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt;
      if (state_r == S_DONE) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (state_r == S_RD) begin
      if (act_r == ACT_CLEAR) count_nxt = '0;
      else if (act_r == ACT_DELETE && count_r != '0) count_nxt = count_r - CW'(1);
    end else if (state_r == S_WR && act_r != ACT_VERTEX && wcnt_r == 2'd3 && append) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        act_r <= in_tuser[2:0]; kind_r <= in_tuser[4:3];
        c_r[0] <= in_tdata[31:0]; c_r[1] <= in_tdata[63:32];
        c_r[2] <= in_tdata[95:64]; c_r[3] <= in_tdata[127:96];
        v_r[0] <= in_tdata[31:0]; v_r[1] <= in_tdata[63:32];
        v_r[2] <= in_tdata[95:64];
        st_r <= ST_OK; idx_r <= '0;
      end
      S_RD: begin
        ld_r <= 3'd0; wcnt_r <= 2'd0;
        ekind_r <= KIND_ROT;
        if (act_r != ACT_VERTEX) idx_r <= last_idx;
        if (act_r == ACT_DELETE && count_r == '0) st_r <= ST_EMPTY;
      end
      S_LOAD: begin
        // Read data arrives in the cycle after each address.
        ld_r <= ld_r + 3'd1;
        if (ld_r >= 3'd1 && ld_r <= 3'd4) e_r[ld_r[1:0] - 2'd1] <= c_rd;
        if (ld_r == 3'd5) begin
          ekind_r <= k_rd;
          if (act_r != ACT_VERTEX && k_rd != kind_r && count_r == CW'(MAX_ENTRIES))
            st_r <= ST_FULL;
        end
        step_r <= '0; mph_r <= 1'b0; acc_r <= '0;
        wcnt_r <= 2'd0;
      end
      S_MUL: begin
        if (!mph_r) begin
          prod_r <= $signed(ma) * $signed(mb);
          mph_r <= 1'b1;
        end else begin
          mph_r <= 1'b0;
          step_r <= step_r + 5'd1;
          if (is_merge && is_rot) begin
            // The old entry is still needed until the last term, so x, y and z
            // are parked in t_r and the whole entry is updated at the end.
            if (step_r[1:0] == 2'd3) begin
              if (step_r[3:2] == 2'd3) begin
                e_r[0] <= t_r[0]; e_r[1] <= t_r[1]; e_r[2] <= t_r[2];
                e_r[3] <= acc_sum;
              end else t_r[step_r[3:2]] <= acc_sum;
              acc_r <= '0;
            end else acc_r <= acc_sum;
          end else if (!is_rot) begin
            if (is_merge) e_r[step_r[1:0]] <= fm;
            else v_r[step_r[1:0]] <= fm;
          end else if (step_r < 5'd6) begin
            if (step_r[0]) begin
              t_r[step_r[2:1]] <= acc_sum << 1; acc_r <= '0;
            end else acc_r <= acc_sum;
          end else if (step_r < 5'd12) begin
            if (step_r[0]) begin
              v_r[2'(step_r[3:1] - 3'd3)] <= v_r[2'(step_r[3:1] - 3'd3)] + acc_sum;
              acc_r <= '0;
            end else acc_r <= acc_sum;
          end else begin
            v_r[2'(step_r - 5'd12)] <= v_r[2'(step_r - 5'd12)] + fm;
          end
        end
      end
      S_WR: begin
        wcnt_r <= wcnt_r + 2'd1;
        ld_r <= 3'd0;
        if (act_r == ACT_VERTEX) begin
          if (ekind_r == KIND_TRANS) begin
            v_r[0] <= v_r[0] + e_r[0]; v_r[1] <= v_r[1] + e_r[1];
            v_r[2] <= v_r[2] + e_r[2];
          end
          idx_r <= idx_r + IW'(1);
        end
      end
      S_DONE: begin
        res_r[0] <= (act_r == ACT_VERTEX) ? v_r[0] : '0;
        res_r[1] <= (act_r == ACT_VERTEX) ? v_r[1] : '0;
        res_r[2] <= (act_r == ACT_VERTEX) ? v_r[2] : '0;
        res_r[3] <= {30'd0, st_r};
      end
      default: ;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {res_r[2], res_r[1], res_r[0]};
  assign out_tuser  = res_r[3][1:0];
endmodule
`default_nettype wire

FILE: rtl/vtc_checker.sv
// Port-level checker for the vertex transform chain, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vtc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  // One item at a time: no new input while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  // A result cannot appear the cycle after an input transaction.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3) else $error("bad status code");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
endmodule

bind vertex_transform_chain vtc_checker u_vtc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser));
`default_nettype wire
